FILE: design/mt_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// MT19937 shared definitions
// Constants, the memory write request type and the tempering function used
// by the generator's state store, seed fill unit and draw pipeline.
// -----------------------------------------------------------------------------
package mt_pkg;

	localparam int WORD_W = 32;
	localparam int STATE_WORDS = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int ADDR_W = $clog2(STATE_WORDS);

	// Position constants for the on-the-fly twist.
	localparam logic [ADDR_W-1:0] POS_LAST = ADDR_W'(STATE_WORDS - 1);
	localparam logic [ADDR_W-1:0] FAR_FWD = ADDR_W'(TWIST_OFFSET);
	localparam logic [ADDR_W-1:0] FAR_BACK = ADDR_W'(STATE_WORDS - TWIST_OFFSET);

	localparam logic [WORD_W-1:0] MATRIX_A = 32'h9908_b0df;
	localparam logic [WORD_W-1:0] TEMPER_B = 32'h9d2c_5680;
	localparam logic [WORD_W-1:0] TEMPER_C = 32'hefc6_0000;
	localparam logic [WORD_W-1:0] SEED_MULT = 32'd1812433253;
	localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;

	// Item codes on the mode field.
	localparam logic MODE_RESEED = 1'b0;
	localparam logic MODE_DRAW = 1'b1;

	// One write into the state store.
	typedef struct packed {
		logic en;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] data;
	} wr_req_t;

	// Output tempering of one state word.
	function automatic logic [WORD_W-1:0] temper(input logic [WORD_W-1:0] w);
		logic [WORD_W-1:0] s;
		s = w;
		s = s ^ (s >> 11);
		s = s ^ ((s << 7) & TEMPER_B);
		s = s ^ ((s << 15) & TEMPER_C);
		s = s ^ (s >> 18);
		return s;
	endfunction

endpackage

FILE: design/mt_state_ram.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// MT19937 state store
// Synchronous memory of 624 words with one write port and two read ports.
// Read data is registered and holds while no read is issued.
// -----------------------------------------------------------------------------
module mt_state_ram (
	input  logic                                   clk,
	input  mt_pkg::wr_req_t                        wr,
	input  logic                                   rd_en,
	input  logic [mt_pkg::ADDR_W-1:0]              rd_addr_a,
	input  logic [mt_pkg::ADDR_W-1:0]              rd_addr_b,
	output logic [mt_pkg::WORD_W-1:0]              rd_data_a,
	output logic [mt_pkg::WORD_W-1:0]              rd_data_b
);
	import mt_pkg::*;

	logic [WORD_W-1:0] mem_q [STATE_WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Two registered read ports sharing one enable.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= mem_q[rd_addr_a];
			rd_data_b <= mem_q[rd_addr_b];
		end
	end

endmodule

FILE: design/mt_seed_fill.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// MT19937 seed fill unit
// Walks the state store one word per cycle, writing the linear recurrence
// seeded from the start word. Runs once after reset with the default seed.
// -----------------------------------------------------------------------------
module mt_seed_fill (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [mt_pkg::WORD_W-1:0] start_word,
	output logic                      busy,
	output mt_pkg::wr_req_t           wr
);
	import mt_pkg::*;

	logic              busy_q;
	logic [ADDR_W-1:0] k_q;
	logic [WORD_W-1:0] word_q;
	logic [WORD_W-1:0] mix;
	logic [WORD_W-1:0] prod;
	logic [WORD_W-1:0] next_word;

	// Next word: multiplier times the folded previous word plus its index.
	assign mix = word_q ^ (word_q >> 30);
	assign prod = SEED_MULT * mix;
	assign next_word = prod + WORD_W'(k_q) + WORD_W'(1);

	// Sequencer over the store.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			k_q <= '0;
			word_q <= DEFAULT_SEED;
		end else if (start) begin
			busy_q <= 1'b1;
			k_q <= '0;
			word_q <= start_word;
		end else if (busy_q) begin
			word_q <= next_word;
			k_q <= k_q + ADDR_W'(1);
			if (k_q == POS_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign busy = busy_q;
	assign wr.en = busy_q;
	assign wr.addr = k_q;
	assign wr.data = word_q;

endmodule

FILE: design/mt_draw_pipe.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// MT19937 draw pipeline
// Regenerates one state word per draw on the fly: reads the next and the far
// word, twists, writes back and tempers into the output register.
// -----------------------------------------------------------------------------
module mt_draw_pipe (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      draw_go,
	input  logic                      restart,
	input  logic [mt_pkg::WORD_W-1:0] restart_word,
	input  logic [mt_pkg::WORD_W-1:0] rd_data_a,
	input  logic [mt_pkg::WORD_W-1:0] rd_data_b,
	input  logic                      out_stall,
	output logic                      rd_en,
	output logic [mt_pkg::ADDR_W-1:0] rd_addr_a,
	output logic [mt_pkg::ADDR_W-1:0] rd_addr_b,
	output mt_pkg::wr_req_t           wr,
	output logic                      blocked,
	output logic                      out_valid,
	output logic [mt_pkg::WORD_W-1:0] random_word
);
	import mt_pkg::*;

	logic [ADDR_W-1:0] pos_q;
	logic [WORD_W-1:0] cur_q;
	logic              valid_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	logic              s1_adv;
	logic [WORD_W-1:0] mixed;
	logic [WORD_W-1:0] twisted;

	// Read addresses for the word after the position and the far word.
	assign rd_en = draw_go;
	assign rd_addr_a = (pos_q == POS_LAST) ? '0 : pos_q + ADDR_W'(1);
	assign rd_addr_b = (pos_q >= FAR_BACK) ? pos_q - FAR_BACK : pos_q + FAR_FWD;

	// The second stage moves on unless the output beat is held.
	assign s1_adv = valid_s1 && !(out_valid_q && out_stall);
	assign blocked = valid_s1 && !s1_adv;

	// Twist of one word. The current word is carried from the previous draw.
	assign mixed = {cur_q[WORD_W-1], rd_data_a[WORD_W-2:0]};
	assign twisted = rd_data_b ^ (mixed >> 1) ^ (rd_data_a[0] ? MATRIX_A : '0);

	assign wr.en = s1_adv;
	assign wr.addr = addr_s1;
	assign wr.data = twisted;

	// Position and carried current word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			cur_q <= DEFAULT_SEED;
		end else if (restart) begin
			pos_q <= '0;
			cur_q <= restart_word;
		end else begin
			if (draw_go) begin
				pos_q <= rd_addr_a;
			end
			if (s1_adv) begin
				cur_q <= rd_data_a;
			end
		end
	end

	// Stage valid and output register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (draw_go) begin
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (draw_go) begin
			addr_s1 <= pos_q;
		end
		if (s1_adv) begin
			out_word_q <= temper(twisted);
		end
	end

	assign out_valid = out_valid_q;
	assign random_word = out_word_q;

	// A draw issued to memory reaches the twist stage next cycle.
	a_draw_enters: assert property (@(posedge clk) disable iff (!arst_n)
		draw_go |=> valid_s1)
		else $error("draw did not reach twist stage");

	// A held twist stage keeps its write address.
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		blocked |=> valid_s1 && $stable(addr_s1))
		else $error("held twist stage lost its word");

	// A twisted word always shows up as an output beat.
	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> out_valid)
		else $error("twisted word did not reach output");

endmodule

FILE: design/mersenne_twister_generator.sv
`timescale 1ns / 1ps
// Draw path: 2 register stages, the state read, then the output register.
// Throughput: one draw per cycle while no fill runs and the output does not stall;
// the dual-port state memory serves each draw. Reseed: the seed fill unit writes
// all 624 store words, one per cycle. Reset: the same fill with seed 5489 runs first;
// no beat is taken until it finishes.
// -----------------------------------------------------------------------------
// MT19937 random word generator
// A reseed beat refills the 624-word state store; a draw beat returns the next
// tempered word, regenerating that state word on the fly.
// -----------------------------------------------------------------------------
module mersenne_twister_generator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      mode,
	input  logic [mt_pkg::WORD_W-1:0] seed,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [mt_pkg::WORD_W-1:0] random_word
);
	import mt_pkg::*;

	logic              in_accept;
	logic              reseed_go;
	logic              draw_go;
	logic [WORD_W-1:0] seed_word;
	logic              fill_busy;
	logic              draw_blocked;
	wr_req_t           fill_wr;
	wr_req_t           draw_wr;
	wr_req_t           mem_wr;
	logic              rd_en;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [WORD_W-1:0] rd_data_a;
	logic [WORD_W-1:0] rd_data_b;

	// Input handshake and item decode.
	assign in_stall = fill_busy || draw_blocked;
	assign in_accept = in_valid && !in_stall;
	assign reseed_go = in_accept && (mode == MODE_RESEED);
	assign draw_go = in_accept && (mode == MODE_DRAW);
	assign seed_word = (seed == '0) ? DEFAULT_SEED : seed;

	// The fill unit and the draw pipeline never write in the same cycle.
	assign mem_wr = fill_wr.en ? fill_wr : draw_wr;

	mt_state_ram u_ram (
		.clk       (clk),
		.wr        (mem_wr),
		.rd_en     (rd_en),
		.rd_addr_a (rd_addr_a),
		.rd_addr_b (rd_addr_b),
		.rd_data_a (rd_data_a),
		.rd_data_b (rd_data_b)
	);

	mt_seed_fill u_fill (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (reseed_go),
		.start_word (seed_word),
		.busy       (fill_busy),
		.wr         (fill_wr)
	);

	mt_draw_pipe u_draw (
		.clk          (clk),
		.arst_n       (arst_n),
		.draw_go      (draw_go),
		.restart      (reseed_go),
		.restart_word (seed_word),
		.rd_data_a    (rd_data_a),
		.rd_data_b    (rd_data_b),
		.out_stall    (out_stall),
		.rd_en        (rd_en),
		.rd_addr_a    (rd_addr_a),
		.rd_addr_b    (rd_addr_b),
		.wr           (draw_wr),
		.blocked      (draw_blocked),
		.out_valid    (out_valid),
		.random_word  (random_word)
	);

	// Only one writer drives the store in any cycle.
	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		!(fill_wr.en && draw_wr.en))
		else $error("fill and draw wrote the store together");

	// A reseed beat starts the fill pass.
	a_reseed_fills: assert property (@(posedge clk) disable iff (!arst_n)
		reseed_go |=> fill_busy)
		else $error("reseed did not start the fill");

	// No draw reads the store while it is being filled.
	a_no_read_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_busy |-> !rd_en)
		else $error("store read during fill");

endmodule

FILE: dv/mersenne_twister_generator_test.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// MT19937 generator testbench
// Drives reseed and draw beats through the input channel and predicts every
// tempered word with a behavioral MT19937 kept in the bench. Each output beat
// is checked in order against the predicted word, while the input side idles
// in bursts and the output side stalls on a changing pattern.
// -----------------------------------------------------------------------------
module mersenne_twister_generator_test;

	import mt_pkg::*;

	localparam int IDLE_LIMIT = 5000;
	localparam int TAIL_CYCLES = 700;
	localparam int RANDOM_BEATS = 30;
	localparam int WRAP_DRAWS = 628;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic mode;
	logic [WORD_W-1:0] seed;
	logic out_valid;
	logic out_stall;
	logic [WORD_W-1:0] random_word;

	// Bench copy of the generator state.
	logic [WORD_W-1:0] twister_store [STATE_WORDS];
	int unsigned twister_pos;

	// Predicted words waiting for their output beat.
	logic [WORD_W-1:0] expected_words [$];

	int unsigned draw_count;
	int unsigned reseed_count;
	int unsigned checked_count;
	int unsigned error_count;
	int unsigned idle_cycles;
	int unsigned burst_left;
	bit valid_held;

	mersenne_twister_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.seed(seed),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.random_word(random_word)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Fill the store from a seed with the linear recurrence; zero means 5489.
	function automatic void seed_store(input logic [WORD_W-1:0] s);
		logic [WORD_W-1:0] prev;
		twister_store[0] = (s == '0) ? DEFAULT_SEED : s;
		for (int k = 1; k < STATE_WORDS; k++) begin
			prev = twister_store[k-1];
			twister_store[k] = SEED_MULT * (prev ^ (prev >> 30)) + WORD_W'(k);
		end
		twister_pos = STATE_WORDS;
	endfunction

	// Regenerate the whole store with the standard twist.
	function automatic void twist_store();
		logic [WORD_W-1:0] nxt;
		logic [WORD_W-1:0] far_word;
		logic [WORD_W-1:0] y;
		logic [WORD_W-1:0] v;
		for (int k = 0; k < STATE_WORDS; k++) begin
			nxt = twister_store[(k + 1) % STATE_WORDS];
			far_word = twister_store[(k + TWIST_OFFSET) % STATE_WORDS];
			y = {twister_store[k][WORD_W-1], nxt[WORD_W-2:0]};
			v = far_word ^ (y >> 1);
			if (nxt[0])
				v = v ^ MATRIX_A;
			twister_store[k] = v;
		end
		twister_pos = 0;
	endfunction

	// Take the next store word and apply the output tempering.
	function automatic logic [WORD_W-1:0] next_word();
		logic [WORD_W-1:0] w;
		if (twister_pos >= STATE_WORDS)
			twist_store();
		w = twister_store[twister_pos];
		twister_pos++;
		w = w ^ (w >> 11);
		w = w ^ ((w << 7) & 32'h9d2c_5680);
		w = w ^ ((w << 15) & 32'hefc6_0000);
		w = w ^ (w >> 18);
		return w;
	endfunction

	// Send one beat, update the prediction when it is taken, then maybe idle.
	task automatic send_beat(input logic m, input logic [WORD_W-1:0] s);
		int unsigned gap;
		in_valid <= 1'b1;
		mode <= m;
		seed <= s;
		valid_held = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (m == MODE_RESEED) begin
			seed_store(s);
			reseed_count++;
		end else begin
			expected_words.push_back(next_word());
			draw_count++;
		end
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 30);
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				seed <= $urandom;
				valid_held = 1'b0;
				repeat (gap) @(posedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	// Lower valid if it is still held; the edge keeps raise and lower apart.
	task automatic release_input();
		if (valid_held) begin
			in_valid <= 1'b0;
			valid_held = 1'b0;
			@(posedge clk);
		end
	endtask

	// Hold the sender until every predicted word has come out.
	task automatic wait_drained();
		release_input();
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	// Draws straight out of reset; the seed field must be ignored.
	task automatic test_reset_stream();
		send_beat(MODE_DRAW, 32'h0000_0000);
		send_beat(MODE_DRAW, 32'hffff_ffff);
		send_beat(MODE_DRAW, $urandom);
		send_beat(MODE_DRAW, 32'h0000_0000);
	endtask

	// Zero and extreme seeds, and two reseeds in a row.
	task automatic test_seed_extremes();
		send_beat(MODE_RESEED, 32'h0000_0000);
		repeat (3) send_beat(MODE_DRAW, $urandom);
		wait_drained();
		send_beat(MODE_RESEED, 32'hffff_ffff);
		repeat (2) send_beat(MODE_DRAW, 32'hffff_ffff);
		send_beat(MODE_RESEED, 32'h0000_0001);
		send_beat(MODE_DRAW, 32'h0000_0000);
		send_beat(MODE_RESEED, 32'h8000_0000);
		send_beat(MODE_RESEED, 32'h7fff_ffff);
		repeat (2) send_beat(MODE_DRAW, $urandom);
	endtask

	// Run past the end of the store so the twist wraps around at least once.
	task automatic test_store_wrap();
		send_beat(MODE_RESEED, $urandom);
		for (int i = 0; i < WRAP_DRAWS; i++)
			send_beat(MODE_DRAW, $urandom);
	endtask

	// Mostly draws with occasional reseeds, some of them zero.
	task automatic test_random_mix();
		logic [WORD_W-1:0] s;
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			if ($urandom_range(0, 99) < 4) begin
				s = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
				send_beat(MODE_RESEED, s);
			end else begin
				send_beat(MODE_DRAW, $urandom);
			end
			if (i % 137 == 136)
				wait_drained();
		end
	endtask

	// Output side stalls on a style that changes every stretch of cycles.
	initial begin
		int unsigned style;
		int unsigned stretch;
		out_stall <= 1'b0;
		forever begin
			style = $urandom_range(0, 3);
			stretch = $urandom_range(20, 200);
			repeat (stretch) begin
				@(posedge clk);
				case (style)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					2: out_stall <= ($urandom_range(0, 9) < 7);
					default: out_stall <= ~out_stall;
				endcase
			end
		end
	end

	// Compare each output beat with the oldest predicted word.
	always @(posedge clk) begin
		logic [WORD_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$display("%0t: unexpected output beat, expected none, actual %h",
					$time, random_word);
				error_count++;
			end else begin
				want = expected_words.pop_front();
				checked_count++;
				if (random_word !== want) begin
					$display("%0t: random_word differs, expected %h, actual %h",
						$time, want, random_word);
					error_count++;
				end
			end
		end
	end

	// End the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		draw_count = 0;
		reseed_count = 0;
		checked_count = 0;
		error_count = 0;
		idle_cycles = 0;
		burst_left = 0;
		valid_held = 1'b0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		mode <= MODE_DRAW;
		seed <= '0;
		seed_store(DEFAULT_SEED);
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_stream();
		test_seed_extremes();
		test_store_wrap();
		test_random_mix();

		// Let the last draws come out and any reseed in flight finish.
		release_input();
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Sent %0d draws and %0d reseeds, %0d words checked, with zero seeds,",
			draw_count, reseed_count, checked_count);
		$display("back-to-back reseeds and a run across the end of the state store.");
		if (error_count == 0 && expected_words.size() == 0) begin
			$display("No mismatches found");
		end else begin
			if (expected_words.size() != 0)
				$display("%0t: %0d predicted words never came out",
					$time, expected_words.size());
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

FILE: files.f
design/mt_pkg.sv
design/mt_state_ram.sv
design/mt_seed_fill.sv
design/mt_draw_pipe.sv
design/mersenne_twister_generator.sv
dv/mersenne_twister_generator_test.sv
